// File: src/signed_seven_segment_serial_driver_unit_defines.svh
// Assertion macros shared by the seven-segment serial driver RTL
`ifndef SIGNED_SEVEN_SEGMENT_SERIAL_DRIVER_UNIT_DEFINES_SVH
`define SIGNED_SEVEN_SEGMENT_SERIAL_DRIVER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/ssd_pkg.sv
// Shared types, constants and segment table for the seven-segment serial driver
package ssd_pkg;

    localparam int DEF_NUM_DIGITS = 4;
    localparam int OPCODE_W       = 2;
    localparam int VALUE_W        = 15;
    localparam int SYM_W          = 4;
    localparam int DIGIT_W        = 2;
    localparam int SEG_BITS       = 8;
    localparam int SEG_IDX_W      = 3;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_SHOW_NUM = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BLANK    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SYMBOL   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;  // dropped, no output

    // Symbol codes
    localparam logic [SYM_W-1:0] SYM_DOT     = 4'd10;
    localparam logic [SYM_W-1:0] SYM_MINUS   = 4'd11;
    localparam logic [SYM_W-1:0] SYM_BLANK   = 4'd12;
    localparam logic [SYM_W-1:0] NUM_SYMBOLS = 4'd13;

    // Divide by ten: q = (x * 52429) >> 19, exact for x below 43690
    localparam int               DIV10_MUL_W = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
    localparam int               DIV10_SHIFT = 19;

    // Control from the sequencer to the digit unit
    typedef struct packed {
        logic load;   // take a new request
        logic mul;    // register quotient of magnitude by ten
        logic rem;    // form digit symbol, shift magnitude down
        logic first;  // current frame is digit position zero
    } t_dig_ctl;

    // 10^n, elaboration only
    function automatic int pow10(input int n);
        int p;
        p = 1;
        for (int k = 0; k < n; k++) begin
            p = p * 10;
        end
        return p;
    endfunction

    // Active-low segment pattern, bit 0 sent first
    function automatic logic [SEG_BITS-1:0] seg_lookup(input logic [SYM_W-1:0] sym);
        logic [SEG_BITS-1:0] seg;
        unique case (sym)
            4'd0:    seg = 8'h03;
            4'd1:    seg = 8'h9F;
            4'd2:    seg = 8'h25;
            4'd3:    seg = 8'h0D;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h49;
            4'd6:    seg = 8'h41;
            4'd7:    seg = 8'h1F;
            4'd8:    seg = 8'h01;
            4'd9:    seg = 8'h09;
            SYM_DOT: seg = 8'hFE;
            SYM_MINUS: seg = 8'hFD;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

endpackage

// File: src/ssd_if.sv
// Request and serial-bit channel interfaces
interface ssd_in_if;
    logic                                valid;
    logic                                ready;
    logic [ssd_pkg::OPCODE_W-1:0]        opcode;
    logic signed [ssd_pkg::VALUE_W-1:0]  value;
    logic [ssd_pkg::SYM_W-1:0]           symbol;
    logic [ssd_pkg::DIGIT_W-1:0]         digit;

    modport source (output valid, opcode, value, symbol, digit, input ready);
    modport sink   (input valid, opcode, value, symbol, digit, output ready);
endinterface

interface ssd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          serial_bit;
    logic                          latch_after;
    logic [ssd_pkg::DIGIT_W-1:0]   frame_digit;
    logic                          last;

    modport source (output valid, serial_bit, latch_after, frame_digit, last, input ready);
    modport sink   (input valid, serial_bit, latch_after, frame_digit, last, output ready);
endinterface

// File: src/ssd_digit_unit.sv
// Shared divide-by-ten unit producing one digit symbol per frame
module ssd_digit_unit #(
    parameter int NUM_DIGITS = ssd_pkg::DEF_NUM_DIGITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssd_pkg::t_dig_ctl                   i_ctl,
    input  logic [ssd_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [ssd_pkg::VALUE_W-1:0]  i_value,
    input  logic [ssd_pkg::SYM_W-1:0]           i_symbol,
    output logic [ssd_pkg::SYM_W-1:0]           o_sym
);

    localparam int VW    = ssd_pkg::VALUE_W;
    localparam int MaxV  = ssd_pkg::pow10(NUM_DIGITS) - 1;
    localparam int MinV  = -(ssd_pkg::pow10(NUM_DIGITS - 1) - 1);
    localparam int RepHi = (1 << (VW - 1)) - 1;
    localparam int RepLo = -(1 << (VW - 1));
    localparam int SatHi = (MaxV > RepHi) ? RepHi : MaxV;
    localparam int SatLo = (MinV < RepLo) ? RepLo : MinV;
    localparam logic signed [VW-1:0] SatHiV = VW'(SatHi);
    localparam logic signed [VW-1:0] SatLoV = VW'(SatLo);
    localparam int ProdW = VW + ssd_pkg::DIV10_MUL_W;

    logic [VW-1:0]                 r_mag;
    logic [VW-1:0]                 r_quo;
    logic                          r_neg;
    logic                          r_placed;
    logic                          r_num;
    logic [ssd_pkg::SYM_W-1:0]     r_sym;

    logic signed [VW-1:0]          v_sat;
    logic signed [VW:0]            v_wide;
    logic [VW-1:0]                 n_mag;
    logic [ProdW-1:0]              prod;
    logic [VW-1:0]                 quo10;
    logic [ssd_pkg::SYM_W-1:0]     rem;

    // Saturate and take magnitude
    always_comb begin
        if (i_value > SatHiV) begin
            v_sat = SatHiV;
        end else if (i_value < SatLoV) begin
            v_sat = SatLoV;
        end else begin
            v_sat = i_value;
        end
        v_wide = (VW+1)'(v_sat);
        n_mag  = v_wide[VW] ? VW'(-v_wide) : VW'(v_wide);
    end

    // Reciprocal multiply, then remainder by shift-add
    always_comb begin
        prod  = ProdW'(r_mag) * ProdW'(ssd_pkg::DIV10_MUL);
        quo10 = VW'({r_quo, 3'b000}) + VW'({r_quo, 1'b0});
        rem   = ssd_pkg::SYM_W'(r_mag - quo10);
    end

    // Magnitude, quotient and symbol registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed <= 1'b0;
            r_num    <= 1'b0;
        end else if (i_ctl.load) begin
            r_mag    <= n_mag;
            r_neg    <= v_sat[VW-1];
            r_placed <= 1'b0;
            r_num    <= (i_opcode == ssd_pkg::OP_SHOW_NUM);
            if (i_opcode == ssd_pkg::OP_SYMBOL && i_symbol < ssd_pkg::NUM_SYMBOLS) begin
                r_sym <= i_symbol;
            end else begin
                r_sym <= ssd_pkg::SYM_BLANK;
            end
        end else if (i_ctl.mul) begin
            r_quo <= VW'(prod >> ssd_pkg::DIV10_SHIFT);
        end else if (i_ctl.rem && r_num) begin
            r_mag <= r_quo;
            // digits while magnitude remains, then one minus, then blanks
            if (i_ctl.first || r_mag != '0) begin
                r_sym <= rem;
            end else if (r_neg && !r_placed) begin
                r_sym    <= ssd_pkg::SYM_MINUS;
                r_placed <= 1'b1;
            end else begin
                r_sym <= ssd_pkg::SYM_BLANK;
            end
        end
    end

    assign o_sym = r_sym;

endmodule

// File: src/signed_seven_segment_serial_driver_unit.sv
// Top level: frame sequencer and serial output register of the seven-segment driver
// The first serial bit is registered after the request is accepted, once the output register is free.
// Throughput: one bit per cycle while the sink is ready; a frame is NUM_DIGITS+8 bits, so a
// number or blank request sends NUM_DIGITS frames and a symbol request one frame; the
// shared divide-by-ten unit works during each frame's selects. An unused opcode is
// accepted and dropped without output. Synchronous active-low reset; idle after reset.
`include "signed_seven_segment_serial_driver_unit_defines.svh"

module signed_seven_segment_serial_driver_unit #(
    parameter int NUM_DIGITS = ssd_pkg::DEF_NUM_DIGITS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ssd_in_if.sink   i_in,
    ssd_out_if.source o_out
);

    localparam int FrameLen = NUM_DIGITS + ssd_pkg::SEG_BITS;
    localparam int BW       = $clog2(FrameLen);
    localparam int PW       = ($clog2(NUM_DIGITS) > ssd_pkg::DIGIT_W) ?
                              $clog2(NUM_DIGITS) : ssd_pkg::DIGIT_W;
    localparam int CW       = (PW > BW) ? PW : BW;
    localparam logic [BW-1:0] LastBit = BW'(FrameLen - 1);
    localparam logic [PW-1:0] LastPos = PW'(NUM_DIGITS - 1);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                          r_state;
    logic [BW-1:0]                   r_bit;
    logic [PW-1:0]                   r_pos;
    logic                            r_single;
    logic                            r_out_valid;
    logic                            r_out_bit;
    logic                            r_out_latch;
    logic [ssd_pkg::DIGIT_W-1:0]     r_out_frame_digit;
    logic                            r_out_last;

    logic                            accept;
    logic                            emit;
    logic                            n_bit_val;
    logic                            frame_end;
    logic                            item_end;
    logic [ssd_pkg::SEG_BITS-1:0]    seg;
    logic [ssd_pkg::SEG_IDX_W-1:0]   seg_idx;
    logic [ssd_pkg::SYM_W-1:0]       sym;
    ssd_pkg::t_dig_ctl               dig_ctl;

    // Handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign emit       = (r_state == S_RUN) && (!r_out_valid || o_out.ready);

    // Current serial bit: one-hot select, then segment bits
    always_comb begin
        seg       = ssd_pkg::seg_lookup(sym);
        seg_idx   = ssd_pkg::SEG_IDX_W'(r_bit - BW'(NUM_DIGITS));
        frame_end = (r_bit == LastBit);
        item_end  = frame_end && (r_single || r_pos == LastPos);
        if (r_bit < BW'(NUM_DIGITS)) begin
            n_bit_val = (CW'(r_bit) == CW'(r_pos));
        end else begin
            n_bit_val = seg[seg_idx];
        end
    end

    // Digit unit steps
    always_comb begin
        dig_ctl.load  = accept;
        dig_ctl.mul   = emit && (r_bit == BW'(0));
        dig_ctl.rem   = emit && (r_bit == BW'(1));
        dig_ctl.first = (r_pos == '0);
    end

    ssd_digit_unit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_digit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (dig_ctl),
        .i_opcode (i_in.opcode),
        .i_value  (i_in.value),
        .i_symbol (i_in.symbol),
        .o_sym    (sym)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_in.opcode != ssd_pkg::OP_UNUSED) begin
                        r_state  <= S_RUN;
                        r_bit    <= '0;
                        r_single <= (i_in.opcode == ssd_pkg::OP_SYMBOL);
                        r_pos    <= (i_in.opcode == ssd_pkg::OP_SYMBOL) ?
                                    PW'(i_in.digit) : '0;
                    end
                end
                S_RUN: begin
                    if (emit) begin
                        if (frame_end) begin
                            r_bit <= '0;
                            r_pos <= r_pos + PW'(1);
                        end else begin
                            r_bit <= r_bit + BW'(1);
                        end
                        if (item_end) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (emit) begin
            r_out_bit         <= n_bit_val;
            r_out_latch       <= frame_end;
            r_out_frame_digit <= r_pos[ssd_pkg::DIGIT_W-1:0];
            r_out_last        <= item_end;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.serial_bit  = r_out_bit;
    assign o_out.latch_after = r_out_latch;
    assign o_out.frame_digit = r_out_frame_digit;
    assign o_out.last        = r_out_last;

    // Checks
    `SSD_ASSERT_NOW(a_last_has_latch, r_out_valid && r_out_last, r_out_latch, "last bit without latch")
    `SSD_ASSERT_NEXT(a_idle_after_last, emit && item_end, r_state == S_IDLE, "no idle after last bit")
    `SSD_ASSERT_NOW(a_accept_at_frame_start, accept, r_bit == '0, "request taken mid-frame")
    `SSD_ASSERT_NEXT(a_frame_wrap, emit && frame_end, r_bit == '0, "frame counter did not wrap")

endmodule

// File: tb/tb_signed_seven_segment_serial_driver_unit.sv
// Self-checking testbench for the seven-segment serial driver: predicted serial frames vs. DUT
module tb_signed_seven_segment_serial_driver_unit;

    localparam int DIGITS     = ssd_pkg::DEF_NUM_DIGITS;
    localparam int SEG_LEN    = ssd_pkg::SEG_BITS;
    localparam int OP_BITS    = ssd_pkg::OPCODE_W;
    localparam int VAL_BITS   = ssd_pkg::VALUE_W;
    localparam int SYM_BITS   = ssd_pkg::SYM_W;
    localparam int POS_BITS   = ssd_pkg::DIGIT_W;
    localparam int FRAME_LEN  = DIGITS + SEG_LEN;
    localparam int MAX_SHOWN  = 10 ** DIGITS - 1;
    localparam int MIN_SHOWN  = -(10 ** (DIGITS - 1) - 1);
    localparam int SETTLE_CYC = 60;
    localparam int MAX_PRINTS = 40;
    localparam int RAND_ITEMS = 388;
    localparam int CALM_TAIL  = 60;

    // active-low segment patterns, bit 0 leaves first
    localparam logic [SEG_LEN-1:0] SEG_PATTERN [13] = '{
        8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09,
        8'hFE, 8'hFD, 8'hFF
    };

    typedef struct packed {
        logic                serial_bit;
        logic                latch_after;
        logic [POS_BITS-1:0] frame_digit;
        logic                last;
    } t_serial_bit;

    // Frame predictor and pending-bit store
    class t_frame_scoreboard;
        t_serial_bit pending_bits[$];
        int unsigned n_errors;
        int unsigned n_bits;
        int unsigned n_requests[4];

        task report(string msg);
            n_errors++;
            if (n_errors <= MAX_PRINTS) begin
                $display("ERROR @%0t: %s", $realtime, msg);
            end
        endtask

        function void push_frame(logic [POS_BITS-1:0] pos, logic [SYM_BITS-1:0] sym,
                                 bit ends);
            t_serial_bit b;
            for (int i = 0; i < FRAME_LEN; i++) begin
                if (i < DIGITS) begin
                    b.serial_bit = (int'(pos) == i);
                end else begin
                    b.serial_bit = SEG_PATTERN[sym][i - DIGITS];
                end
                b.latch_after = (i == FRAME_LEN - 1);
                b.frame_digit = pos;
                b.last        = ends && (i == FRAME_LEN - 1);
                pending_bits.push_back(b);
            end
        endfunction

        // Work out the serial bits one accepted request produces
        function void note_request(logic [OP_BITS-1:0] op, logic signed [VAL_BITS-1:0] val,
                                   logic [SYM_BITS-1:0] sym, logic [POS_BITS-1:0] dig);
            logic [SYM_BITS-1:0] shown [DIGITS];
            int  v;
            int  mag;
            int  n;
            bit  neg;
            n_requests[op]++;
            if (op == ssd_pkg::OP_UNUSED) begin
                return;
            end
            if (op == ssd_pkg::OP_SYMBOL) begin
                push_frame(dig, (sym < ssd_pkg::NUM_SYMBOLS) ? sym : ssd_pkg::SYM_BLANK,
                           1'b1);
                return;
            end
            for (int i = 0; i < DIGITS; i++) begin
                shown[i] = ssd_pkg::SYM_BLANK;
            end
            if (op == ssd_pkg::OP_SHOW_NUM) begin
                v = int'(val);
                if (v > MAX_SHOWN) v = MAX_SHOWN;
                if (v < MIN_SHOWN) v = MIN_SHOWN;
                neg = (v < 0);
                mag = neg ? -v : v;
                n   = 0;
                // least significant digit first, at least one digit
                do begin
                    shown[n] = SYM_BITS'(mag % 10);
                    mag      = mag / 10;
                    n++;
                end while (mag != 0 && n < DIGITS);
                if (neg && n < DIGITS) begin
                    shown[n] = ssd_pkg::SYM_MINUS;
                end
            end
            for (int i = 0; i < DIGITS; i++) begin
                push_frame(POS_BITS'(i), shown[i], i == DIGITS - 1);
            end
        endfunction

        task check_result(t_serial_bit got);
            t_serial_bit want;
            n_bits++;
            if (pending_bits.size() == 0) begin
                report($sformatf("unexpected bit: bit=%b latch=%b digit=%0d last=%b",
                                 got.serial_bit, got.latch_after, got.frame_digit, got.last));
            end else begin
                want = pending_bits.pop_front();
                if (got !== want) begin
                    report($sformatf({"bit %0d: got bit=%b latch=%b digit=%0d last=%b, ",
                                      "want bit=%b latch=%b digit=%0d last=%b"},
                                     n_bits, got.serial_bit, got.latch_after, got.frame_digit,
                                     got.last, want.serial_bit, want.latch_after,
                                     want.frame_digit, want.last));
                end
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   src_idle_on;
    bit   sink_idle_on;
    int   sink_hold;

    ssd_in_if  in_ch ();
    ssd_out_if out_ch ();

    t_frame_scoreboard sb = new();

    signed_seven_segment_serial_driver_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = '0;
        in_ch.value   = '0;
        in_ch.symbol  = '0;
        in_ch.digit   = '0;
        out_ch.ready  = 1'b0;
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold     = 0;
    end

    // Sink side: ready with random stall bursts
    always @(posedge clk) begin
        if (sink_idle_on && sink_hold == 0 && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 5);
        end
        if (sink_hold > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Note accepted requests
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_request(in_ch.opcode, in_ch.value, in_ch.symbol, in_ch.digit);
        end
    end

    // Check accepted serial bits
    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result({out_ch.serial_bit, out_ch.latch_after, out_ch.frame_digit,
                             out_ch.last});
        end
    end

    // Drive one request, holding it until the block takes it
    task send_request(logic [OP_BITS-1:0] op, logic signed [VAL_BITS-1:0] val,
                      logic [SYM_BITS-1:0] sym, logic [POS_BITS-1:0] dig);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= val;
        in_ch.symbol <= sym;
        in_ch.digit  <= dig;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Hold off the sender until every predicted bit has come out;
    // the check follows a clock edge, so the last request is already noted
    task drain_pending();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_bits.size() != 0);
    endtask

    task send_random_request();
        logic [OP_BITS-1:0]         op;
        logic signed [VAL_BITS-1:0] val;
        int                         pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = ssd_pkg::OP_SHOW_NUM;
        else if (pick < 65) op = ssd_pkg::OP_BLANK;
        else if (pick < 95) op = ssd_pkg::OP_SYMBOL;
        else                op = ssd_pkg::OP_UNUSED;
        pick = $urandom_range(0, 9);
        if (pick < 6)      val = VAL_BITS'($urandom_range(0, MAX_SHOWN - MIN_SHOWN) + MIN_SHOWN);
        else if (pick < 8) val = VAL_BITS'($urandom_range(0, 40) - 20);
        else               val = VAL_BITS'($urandom);
        send_request(op, val, SYM_BITS'($urandom), POS_BITS'($urandom));
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: value extremes, saturation, every opcode and symbol corner
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd0, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd9999, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, -15'sd999, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd10000, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd16383, 4'd15, 2'd3);
        send_request(ssd_pkg::OP_SHOW_NUM, -15'sd16384, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, -15'sd1000, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, -15'sd1, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, -15'sd42, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd7, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd1000, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd1234, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_BLANK, -15'sd1, 4'd15, 2'd3);
        send_request(ssd_pkg::OP_UNUSED, 15'sd5, 4'd3, 2'd1);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, 4'd0, 2'd0);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, 4'd9, 2'd1);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, ssd_pkg::SYM_DOT, 2'd2);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, ssd_pkg::SYM_MINUS, 2'd3);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, ssd_pkg::SYM_BLANK, 2'd0);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, 4'd13, 2'd1);
        send_request(ssd_pkg::OP_SYMBOL, 15'sd0, 4'd15, 2'd3);
        send_request(ssd_pkg::OP_SHOW_NUM, 15'sd88, 4'd0, 2'd0);
        drain_pending();

        // Random: calm and idle stretches are mixed at random, fully calm at the end
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 30 == 0) begin
                src_idle_on  = (k < RAND_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
                sink_idle_on = (k < RAND_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            end
            if (k % 97 == 50) begin
                drain_pending();
            end
            send_random_request();
        end
        drain_pending();

        repeat (SETTLE_CYC) @(posedge clk);
        if (sb.pending_bits.size() != 0) begin
            sb.report($sformatf("%0d predicted bits never arrived", sb.pending_bits.size()));
        end

        $display("Covered %0d number, %0d blank, %0d symbol and %0d unused-opcode requests,",
                 sb.n_requests[ssd_pkg::OP_SHOW_NUM], sb.n_requests[ssd_pkg::OP_BLANK],
                 sb.n_requests[ssd_pkg::OP_SYMBOL], sb.n_requests[ssd_pkg::OP_UNUSED]);
        $display("checked %0d serial bits with %0d errors.", sb.n_bits, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("signed_seven_segment_serial_driver_unit: match");
        end else begin
            $display("signed_seven_segment_serial_driver_unit: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(8_000_000);
        $display("Timeout with %0d bits still pending", sb.pending_bits.size());
        $display("signed_seven_segment_serial_driver_unit: mismatch");
        $finish;
    end

endmodule
